@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk, disabled while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never hold at a clock edge.
`define ASSERT_NEVER(label, expr, msg) \
	`ASSERT_CLK(label, !(expr), msg)

`endif

@@ hdl/cda_pkg.sv @@
// Package for the date adder: widths, codes, constants, control structs, month table.
`default_nettype none
package cda_pkg;

	localparam int MONTH_W = 4;
	localparam int DAY_W = 5;
	localparam int YEAR_W = 14;
	localparam int ADD_W = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [YEAR_W-1:0] MAX_YEAR = YEAR_W'(9999);
	localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
	localparam logic [DAY_W-1:0] DAY_FIRST = DAY_W'(1);
	localparam logic [DAY_W-1:0] DAY_LAST_DEC = DAY_W'(31);

	localparam logic [STATUS_W-1:0] ST_OK = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_BAD_DATE = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = STATUS_W'(2);

	// year / 100 as (year * RECIP_100) >> RECIP_SHIFT, exact for any 14-bit year
	localparam int RECIP_W = 13;
	localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W = YEAR_W + RECIP_W;
	localparam int CENT_W = PROD_W - RECIP_SHIFT;
	localparam int REM_W = 7;
	localparam logic [REM_W-1:0] REM_LAST = REM_W'(99);
	localparam int HUNDRED = 100;

	typedef struct packed {
		logic load;   // take a new year and start the split
		logic split;  // finish year mod 100 and century mod 4
		logic incr;   // step to the next year
	} yr_ctl_t;

	typedef struct packed {
		logic [DAY_W-1:0] dim;    // length of the current month
		logic             roll;   // count runs past the month end
		logic [DAY_W-1:0] d_next; // day when the count ends in this month
	} step_stat_t;

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			MONTH_FEB:                  len = leap ? DAY_W'(29) : DAY_W'(28);
			4'd4, 4'd6, 4'd9, 4'd11:    len = DAY_W'(30);
			default:                    len = DAY_W'(31);
		endcase
		return len;
	endfunction

endpackage
`default_nettype wire

@@ hdl/cda_year_track.sv @@
// Year register with running mod-100 and century mod-4 counters for the leap rule.
`default_nettype none
module cda_year_track
	import cda_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire yr_ctl_t           ctl,
	input  wire logic [YEAR_W-1:0] year_in,
	output logic      [YEAR_W-1:0] year,
	output logic                   leap
);

	logic [YEAR_W-1:0] y_q;
	logic [PROD_W-1:0] prod_q;
	logic [REM_W-1:0]  rem_q;   // year mod 100
	logic [1:0]        cen_q;   // (year / 100) mod 4

	logic [CENT_W-1:0] cent;
	logic [YEAR_W:0]   rem_full;

	assign cent     = prod_q[PROD_W-1:RECIP_SHIFT];
	assign rem_full = (YEAR_W+1)'({1'b0, y_q}) - (YEAR_W+1)'(cent * CENT_W'(HUNDRED));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_q    <= '0;
			prod_q <= '0;
			rem_q  <= '0;
			cen_q  <= '0;
		end else begin
			if (ctl.load) begin
				y_q    <= year_in;
				prod_q <= PROD_W'(year_in) * PROD_W'(RECIP_100);
			end else if (ctl.split) begin
				rem_q <= rem_full[REM_W-1:0];
				cen_q <= cent[1:0];
			end else if (ctl.incr) begin
				y_q <= y_q + YEAR_W'(1);
				if (rem_q == REM_LAST) begin
					rem_q <= '0;
					cen_q <= cen_q + 2'd1;
				end else begin
					rem_q <= rem_q + REM_W'(1);
				end
			end
		end
	end

	assign year = y_q;
	// div by 4, and not by 100 unless by 400
	assign leap = (y_q[1:0] == 2'd0) && ((rem_q != '0) || (cen_q == 2'd0));

endmodule
`default_nettype wire

@@ hdl/cda_step_unit.sv @@
// Shared month step: month length, compare of count against days left, next count.
`default_nettype none
module cda_step_unit
	import cda_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic [MONTH_W-1:0]    month,
	input  wire logic [DAY_W-1:0]      day,
	input  wire logic                  leap,
	input  wire logic [COUNT_BITS-1:0] cnt,
	output step_stat_t                 stat,
	output logic      [COUNT_BITS-1:0] cnt_next
);

	logic [DAY_W-1:0] dim;
	logic [DAY_W-1:0] left;

	assign dim  = month_days(month, leap);
	assign left = dim - day;

	assign stat.dim    = dim;
	assign stat.roll   = cnt > COUNT_BITS'(left);
	assign stat.d_next = day + cnt[DAY_W-1:0];
	// roll: consume the rest of this month plus day 1 of the next
	assign cnt_next    = stat.roll ? (cnt - COUNT_BITS'(left) - COUNT_BITS'(1)) : '0;

endmodule
`default_nettype wire

@@ hdl/calendar_date_add_days.sv @@
// Top level: Gregorian date plus day count, one month per cycle under a small sequencer.
//
//  channel  | handshake              | word
//  ---------+------------------------+-------------------------------------------
//  command  | start, busy            | start_month, start_day, start_year, add_count
//  result   | done (1-cycle strobe)  | end_month, end_day, end_year, status
//
// A command is taken when start is high and busy is low; busy then stays high.
// A command is loaded, its year split and the start date checked, then the months
// crossed are stepped through, and the result is posted.
// An invalid start date posts its result from the check state, without stepping.
// done pulses one cycle with the result; it cannot be stalled. busy drops with done.
// Reset (arst_n low) returns to idle with no result pending.
`default_nettype none
module calendar_date_add_days
	import cda_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [MONTH_W-1:0]  start_month,
	input  wire logic [DAY_W-1:0]    start_day,
	input  wire logic [YEAR_W-1:0]   start_year,
	input  wire logic [ADD_W-1:0]    add_count,
	output logic                     done,
	output logic      [MONTH_W-1:0]  end_month,
	output logic      [DAY_W-1:0]    end_day,
	output logic      [YEAR_W-1:0]   end_year,
	output logic      [STATUS_W-1:0] status
);

`include "assert_macros.svh"

	// only the low COUNT_BITS bits of the count take part
	localparam int LOAD_W = (COUNT_BITS < ADD_W) ? COUNT_BITS : ADD_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SPLIT,  // year mod 100 and century mod 4 settle
		S_CHECK,  // start date validation
		S_RUN     // one month per cycle
	} state_t;

	state_t                  state_q;
	logic [MONTH_W-1:0]      m_q;
	logic [DAY_W-1:0]        d_q;
	logic [COUNT_BITS-1:0]   n_q;
	logic                    done_q;
	logic [MONTH_W-1:0]      end_month_q;
	logic [DAY_W-1:0]        end_day_q;
	logic [YEAR_W-1:0]       end_year_q;
	logic [STATUS_W-1:0]     status_q;

	logic                    accept;
	yr_ctl_t                 yr_ctl;
	logic [YEAR_W-1:0]       year;
	logic                    leap;
	step_stat_t              stat;
	logic [COUNT_BITS-1:0]   n_next;
	logic                    bad_date;
	logic                    at_max;

	assign accept = start && (state_q == S_IDLE);

	cda_year_track u_year (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (yr_ctl),
		.year_in (start_year),
		.year    (year),
		.leap    (leap)
	);

	cda_step_unit #(
		.COUNT_BITS (COUNT_BITS)
	) u_step (
		.month    (m_q),
		.day      (d_q),
		.leap     (leap),
		.cnt      (n_q),
		.stat     (stat),
		.cnt_next (n_next)
	);

	// validation reuses the step unit's month length
	assign bad_date = (m_q < MONTH_JAN) || (m_q > MONTH_DEC) || (year > MAX_YEAR) ||
		(d_q == '0) || (d_q > stat.dim);

	assign at_max = (year >= MAX_YEAR);

	always_comb begin
		yr_ctl.load  = accept;
		yr_ctl.split = (state_q == S_SPLIT);
		// December roll with room left in the year range
		yr_ctl.incr  = (state_q == S_RUN) && (n_q != '0) && stat.roll &&
			(m_q == MONTH_DEC) && !at_max;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			m_q         <= '0;
			d_q         <= '0;
			n_q         <= '0;
			done_q      <= 1'b0;
			end_month_q <= '0;
			end_day_q   <= '0;
			end_year_q  <= '0;
			status_q    <= ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						m_q     <= start_month;
						d_q     <= start_day;
						n_q     <= COUNT_BITS'(add_count[LOAD_W-1:0]);
						state_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (bad_date) begin
						end_month_q <= '0;
						end_day_q   <= '0;
						end_year_q  <= '0;
						status_q    <= ST_BAD_DATE;
						done_q      <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (n_q == '0) begin
						end_month_q <= m_q;
						end_day_q   <= d_q;
						end_year_q  <= year;
						status_q    <= ST_OK;
						done_q      <= 1'b1;
						state_q     <= S_IDLE;
					end else if (!stat.roll) begin
						// count ends inside this month
						d_q <= stat.d_next;
						n_q <= '0;
					end else if (m_q == MONTH_DEC && at_max) begin
						// past 12/31/9999: saturate
						end_month_q <= MONTH_DEC;
						end_day_q   <= DAY_LAST_DEC;
						end_year_q  <= MAX_YEAR;
						status_q    <= ST_OVERFLOW;
						done_q      <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						d_q <= DAY_FIRST;
						n_q <= n_next;
						m_q <= (m_q == MONTH_DEC) ? MONTH_JAN : (m_q + MONTH_W'(1));
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign end_month = end_month_q;
	assign end_day   = end_day_q;
	assign end_year  = end_year_q;
	assign status    = status_q;

	`ASSERT_CLK(a_done_idle, done |-> !busy, "result posted while still busy")
	`ASSERT_CLK(a_take_busy, (start && !busy) |=> busy, "command taken but busy not raised")
	`ASSERT_CLK(a_done_pulse, done |=> !done, "result strobe longer than one cycle")
	`ASSERT_CLK(a_ok_range, (done && status == ST_OK) |->
		(end_day != '0 && end_month >= MONTH_JAN && end_month <= MONTH_DEC),
		"ok result with a date out of range")
	`ASSERT_CLK(a_sat_date, (done && status == ST_OVERFLOW) |->
		(end_year == MAX_YEAR && end_month == MONTH_DEC && end_day == DAY_LAST_DEC),
		"overflow result not saturated to the last date")
	`ASSERT_NEVER(a_status_code, done && status > ST_OVERFLOW, "undefined status code")

endmodule
`default_nettype wire
